@@ hw/rtl/lsdmc_pkg.sv @@
package lsdmc_pkg;

  // Defaults for the top-level parameters
  localparam int STACK_DEPTH_DEF = 64;
  localparam int NUM_SIZES_DEF   = 4;
  localparam int ADDR_BITS_DEF   = 24;

  // Fixed field widths
  localparam int COUNT_W = 32;
  localparam int SIZE_W  = 7;
  localparam int ACT_W   = 3;
  localparam int SIDX_W  = 2;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;
  localparam int REG_W   = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation codes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Register indexes (byte address 4*index)
  localparam logic [REG_W-1:0] REG_ACTIVE = 3'd0;
  localparam logic [REG_W-1:0] REG_SIZE0  = 3'd1;

  localparam int NUM_SIZE_REGS = 4;

  // Capacity reset values; sizes without a register keep SIZE_RESET_EXTRA
  localparam logic [SIZE_W-1:0] SIZE_RESET [NUM_SIZE_REGS] = '{7'd8, 7'd16, 7'd32, 7'd64};
  localparam logic [SIZE_W-1:0] SIZE_RESET_EXTRA  = 7'd64;
  localparam logic [ACT_W-1:0]  ACTIVE_RESET      = 3'd4;

endpackage

@@ hw/rtl/lsdmc_stack.sv @@
module lsdmc_stack
  import lsdmc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  localparam int PW = $clog2(STACK_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic                 update,
  output logic                 hit,
  output logic [PW-1:0]        pos
);

  logic [ADDR_BITS-1:0]   stack_r [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] valid_r;
  logic [STACK_DEPTH-1:0] match;
  logic [PW-1:0]          pos_enc;
  logic [PW-1:0]          pos_eff;

  // Parallel tag match; addresses in the stack are unique
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      match[i] = valid_r[i] && (stack_r[i] == addr);
    end
  end

  // One-hot to binary
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (match[i]) begin
        pos_enc = pos_enc | PW'(i);
      end
    end
  end

  assign hit     = |match;
  assign pos     = pos_enc;
  // on a miss the bottom entry drops out
  assign pos_eff = hit ? pos_enc : PW'(STACK_DEPTH - 1);

  // Stack data: shift down through the hit position, new address on top
  always_ff @(posedge clk) begin
    if (update) begin
      stack_r[0] <= addr;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        if (PW'(i) <= pos_eff) begin
          stack_r[i] <= stack_r[i-1];
        end
      end
    end
  end

  // Valid bits follow the same shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (update) begin
      valid_r[0] <= 1'b1;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        if (PW'(i) <= pos_eff) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

endmodule

@@ hw/rtl/lsdmc_report.sv @@
module lsdmc_report
  import lsdmc_pkg::*;
#(
  parameter int NUM_SIZES = NUM_SIZES_DEF,
  localparam int IW = (NUM_SIZES > 1) ? $clog2(NUM_SIZES) : 1,
  localparam int LW = $clog2(NUM_SIZES + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic [LW-1:0]                     total,
  input  logic [NUM_SIZES-1:0][COUNT_W-1:0] counts,
  output logic                              free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SIDX_W-1:0]                 out_size_index,
  output logic [COUNT_W-1:0]                out_miss_count,
  output logic                              out_last_of_report
);

  logic                              busy_r;
  logic [IW-1:0]                     idx_r;
  logic [LW-1:0]                     total_r;
  logic [NUM_SIZES-1:0][COUNT_W-1:0] buf_r;
  logic                              last;
  logic                              take;

  assign last = (LW'(idx_r) + LW'(1)) == total_r;
  assign take = busy_r && out_ready;
  assign free = !busy_r || (take && last);

  assign out_valid          = busy_r;
  assign out_size_index     = SIDX_W'(idx_r);
  assign out_miss_count     = buf_r[idx_r];
  assign out_last_of_report = last;

  // Snapshot of the counters; drained one count per item
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r   <= counts;
      total_r <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= (total != '0);
      idx_r  <= '0;
    end else if (take) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/lru_stack_distance_miss_counter.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | in_operation, in_block_address
// out      | out_valid / out_ready| out_size_index, out_miss_count,
//          |                      | out_last_of_report
// config   | APB psel/penable     | paddr, pwdata, prdata (pready tied high)
//
// An access in the input register does tag match, stack shift and counter update
// in the same cycle, so accesses flow at one per cycle unless a report waits.
// A report snapshots and clears the counters and drains one count per cycle
// with out_ready high from the report buffer; a second report waits in the
// input register until the buffer is empty. Synchronous active-low reset
// empties the stack and clears the counters; no clearing pass is needed.
module lru_stack_distance_miss_counter
  import lsdmc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_SIZES   = NUM_SIZES_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [ADDR_BITS-1:0] in_block_address,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SIDX_W-1:0]    out_size_index,
  output logic [COUNT_W-1:0]   out_miss_count,
  output logic                 out_last_of_report,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  localparam int PW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(NUM_SIZES + 1);
  localparam int DW = (PW + 1 > SIZE_W) ? PW + 1 : SIZE_W;

  // Configuration registers
  logic [ACT_W-1:0]  active_r;
  logic [SIZE_W-1:0] cap_r [NUM_SIZES];
  logic [REG_W-1:0]  reg_idx;
  logic              cfg_wr;

  // Input register
  logic                 item_vld_r;
  logic                 op_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic                 advance;
  logic                 do_access;
  logic                 do_report;

  // Lookup and counters
  logic                              hit;
  logic [PW-1:0]                     pos;
  logic [DW-1:0]                     stack_dist;
  logic [LW-1:0]                     live;
  logic [NUM_SIZES-1:0][COUNT_W-1:0] cnt_r;
  logic                              rpt_free;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr && (reg_idx == REG_ACTIVE)) begin
      active_r <= pwdata[ACT_W-1:0];
    end
  end

  for (genvar k = 0; k < NUM_SIZES; k++) begin : g_cap
    if (k < NUM_SIZE_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cap_r[k] <= SIZE_RESET[k];
        end else if (cfg_wr && (reg_idx == (REG_SIZE0 + REG_W'(k)))) begin
          cap_r[k] <= pwdata[SIZE_W-1:0];
        end
      end
    end else begin : g_fixed
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cap_r[k] <= SIZE_RESET_EXTRA;
        end
      end
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_ACTIVE) begin
      prdata = DATA_W'(active_r);
    end
    for (int k = 0; k < NUM_SIZES; k++) begin
      if ((k < NUM_SIZE_REGS) && (reg_idx == (REG_SIZE0 + REG_W'(k)))) begin
        prdata = DATA_W'(cap_r[k]);
      end
    end
  end

  // Input register; a report waits here while the report buffer drains
  assign do_access = item_vld_r && (op_r == OP_ACCESS);
  assign do_report = item_vld_r && (op_r == OP_REPORT) && rpt_free;
  assign advance   = do_access || do_report;
  assign in_ready  = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r   <= in_operation;
      addr_r <= in_block_address;
    end
  end

  lsdmc_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .addr   (addr_r),
    .update (do_access),
    .hit    (hit),
    .pos    (pos)
  );

  // Sizes in use, clamped to the number built
  assign live = ((ACT_W + 1)'(active_r) > (ACT_W + 1)'(NUM_SIZES)) ?
                LW'(NUM_SIZES) : LW'(active_r);

  // Stack distance, 1-based
  assign stack_dist = DW'(pos) + DW'(1);

  // Saturating miss counters, cleared by a report
  for (genvar k = 0; k < NUM_SIZES; k++) begin : g_cnt
    logic miss;
    assign miss = !hit || (stack_dist > DW'(cap_r[k]));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[k] <= '0;
      end else if (do_report) begin
        cnt_r[k] <= '0;
      end else if (do_access && (LW'(k) < live) && miss && (cnt_r[k] != COUNT_MAX)) begin
        cnt_r[k] <= cnt_r[k] + COUNT_W'(1);
      end
    end
  end

  lsdmc_report #(
    .NUM_SIZES (NUM_SIZES)
  ) u_report (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (do_report),
    .total              (live),
    .counts             (cnt_r),
    .free               (rpt_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_size_index     (out_size_index),
    .out_miss_count     (out_miss_count),
    .out_last_of_report (out_last_of_report)
  );

endmodule

@@ verif/tb_lru_stack_distance_miss_counter.sv @@
module tb_lru_stack_distance_miss_counter;
  import lsdmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW           = ADDR_BITS_DEF;
  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int NSIZES       = NUM_SIZES_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 40;

  localparam logic [REG_W-1:0] REG_SIZE_LAST = REG_SIZE0 + REG_W'(NUM_SIZE_REGS - 1);

  typedef struct packed {
    logic [SIDX_W-1:0]  size_index;
    logic [COUNT_W-1:0] miss_count;
    logic               last_of_report;
  } count_item_t;

  typedef struct {
    logic                    op;
    logic [AW-1:0]           addr;
    bit                      typed;
    logic [0:3][COUNT_W-1:0] want;
  } trace_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_operation;
  logic [AW-1:0]        in_block_address;
  logic                 out_valid;
  logic                 out_ready;
  logic [SIDX_W-1:0]    out_size_index;
  logic [COUNT_W-1:0]   out_miss_count;
  logic                 out_last_of_report;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  // Predicted block state
  logic [AW-1:0]        recency [DEPTH];
  bit                   recency_vld [DEPTH];
  logic [COUNT_W-1:0]   misses [NSIZES];
  logic [ACT_W-1:0]     n_sizes_cfg;
  logic [SIZE_W-1:0]    capacity [NSIZES];

  count_item_t          pending_counts [$];

  int  errors;
  int  items_sent;
  int  reports_sent;
  int  counts_checked;
  int  settings_used;
  bit  gap_on;
  bit  stall_on;

  // Directed trace: typed counts apply right after reset with default sizes 8/16/32/64
  trace_row_t directed [20] = '{
    '{OP_REPORT, 24'h000000, 1'b1, {32'd0, 32'd0, 32'd0, 32'd0}},
    '{OP_ACCESS, 24'h000000, 1'b0, '0},
    '{OP_ACCESS, 24'hFFFFFF, 1'b0, '0},
    '{OP_ACCESS, 24'h000000, 1'b0, '0},
    '{OP_ACCESS, 24'hAAAAAA, 1'b0, '0},
    '{OP_ACCESS, 24'h555555, 1'b0, '0},
    '{OP_REPORT, 24'hFFFFFF, 1'b1, {32'd4, 32'd4, 32'd4, 32'd4}},
    '{OP_REPORT, 24'h000000, 1'b1, {32'd0, 32'd0, 32'd0, 32'd0}},
    '{OP_ACCESS, 24'h000100, 1'b0, '0},
    '{OP_ACCESS, 24'h000101, 1'b0, '0},
    '{OP_ACCESS, 24'h000102, 1'b0, '0},
    '{OP_ACCESS, 24'h000103, 1'b0, '0},
    '{OP_ACCESS, 24'h000104, 1'b0, '0},
    '{OP_ACCESS, 24'h000105, 1'b0, '0},
    '{OP_ACCESS, 24'h000106, 1'b0, '0},
    '{OP_ACCESS, 24'h000107, 1'b0, '0},
    '{OP_ACCESS, 24'h000108, 1'b0, '0},
    // distance 9: misses only the 8-block cache
    '{OP_ACCESS, 24'h000100, 1'b0, '0},
    '{OP_ACCESS, 24'h000100, 1'b0, '0},
    '{OP_REPORT, 24'h000000, 1'b1, {32'd10, 32'd9, 32'd9, 32'd9}}
  };

  // Per-phase settings: active count, four capacities, address pool size, random flag
  int unsigned ph_act  [NUM_PHASES] = '{4, 7, 0, 1, 5, 3, 0, 4};
  int unsigned ph_size [NUM_PHASES][4] = '{
    '{1, 2, 3, 4}, '{64, 127, 0, 32}, '{8, 16, 32, 64}, '{5, 64, 64, 64},
    '{40, 10, 20, 7}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{8, 16, 32, 64}
  };
  int unsigned ph_pool [NUM_PHASES] = '{6, 80, 10, 8, 48, 30, 70, 20};
  bit          ph_rand [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 1, 0};

  lru_stack_distance_miss_counter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_size_index     (out_size_index),
    .out_miss_count     (out_miss_count),
    .out_last_of_report (out_last_of_report),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Access: find stack distance, count misses per size, move address to top
  function automatic void track_access(input logic [AW-1:0] addr);
    int hit_at;
    int n;
    hit_at = -1;
    n = (n_sizes_cfg > NSIZES) ? NSIZES : int'(n_sizes_cfg);
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_at < 0 && recency_vld[i] && recency[i] == addr) hit_at = i;
    end
    for (int k = 0; k < n; k++) begin
      if (hit_at < 0 || hit_at + 1 > int'(capacity[k])) begin
        if (misses[k] != COUNT_MAX) misses[k] = misses[k] + 1'b1;
      end
    end
    // a miss on a full stack drops the bottom entry
    if (hit_at < 0) hit_at = DEPTH - 1;
    for (int i = hit_at; i > 0; i--) begin
      recency[i]     = recency[i-1];
      recency_vld[i] = recency_vld[i-1];
    end
    recency[0]     = addr;
    recency_vld[0] = 1'b1;
  endfunction

  // Report: one count per active size, then clear every counter
  function automatic void drain_counters(input bit typed, input logic [0:3][COUNT_W-1:0] want);
    int n;
    count_item_t c;
    n = (n_sizes_cfg > NSIZES) ? NSIZES : int'(n_sizes_cfg);
    for (int k = 0; k < n; k++) begin
      c.size_index     = SIDX_W'(k);
      c.miss_count     = typed ? want[k] : misses[k];
      c.last_of_report = (k == n - 1);
      pending_counts.push_back(c);
    end
    for (int k = 0; k < NSIZES; k++) misses[k] = '0;
  endfunction

  // Send one item with an optional random lead gap; predict on acceptance
  task automatic send_item(input logic op, input logic [AW-1:0] addr, input bit typed,
                           input logic [0:3][COUNT_W-1:0] want);
    int gap;
    gap = gap_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_block_address <= addr;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
    if (op == OP_REPORT) begin
      reports_sent++;
      drain_counters(typed, want);
    end else begin
      track_access(addr);
    end
  endtask

  // Hold off input until every predicted count has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; mirror into predicted config
  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_ACTIVE) begin
      n_sizes_cfg = data[ACT_W-1:0];
    end else if (idx >= REG_SIZE0 && idx <= REG_SIZE_LAST) begin
      capacity[idx - REG_SIZE0] = data[SIZE_W-1:0];
    end
    @(posedge clk);
  endtask

  // Result side: random stalls, compare against oldest prediction
  initial begin
    count_item_t exp_c;
    int stall;
    out_ready <= 1'b0;
    stall_on = 1'b1;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = stall_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_counts.size() == 0) begin
        $error("unexpected count: size_index %0d miss_count %0d", out_size_index,
               out_miss_count);
        errors++;
      end else begin
        exp_c = pending_counts.pop_front();
        counts_checked++;
        if (out_size_index !== exp_c.size_index) begin
          $error("size_index: expected %0d, got %0d", exp_c.size_index, out_size_index);
          errors++;
        end
        if (out_miss_count !== exp_c.miss_count) begin
          $error("miss_count: expected %0d, got %0d", exp_c.miss_count, out_miss_count);
          errors++;
        end
        if (out_last_of_report !== exp_c.last_of_report) begin
          $error("last_of_report: expected %0d, got %0d", exp_c.last_of_report,
                 out_last_of_report);
          errors++;
        end
      end
      // switch between stalling and streaming now and then
      if (counts_checked % 24 == 0) stall_on = $urandom_range(0, 1);
    end
  end

  // Stimulus
  initial begin
    logic [AW-1:0]   base;
    logic [AW-1:0]   addr;
    logic [DATA_W-1:0] junk;
    int unsigned     act;
    int unsigned     sz [4];
    errors         = 0;
    items_sent     = 0;
    reports_sent   = 0;
    counts_checked = 0;
    settings_used  = 0;
    gap_on         = 1'b1;
    n_sizes_cfg    = ACTIVE_RESET;
    for (int k = 0; k < NSIZES; k++) begin
      capacity[k] = (k < NUM_SIZE_REGS) ? SIZE_RESET[k] : SIZE_RESET_EXTRA;
      misses[k]   = '0;
    end
    for (int i = 0; i < DEPTH; i++) begin
      recency[i]     = '0;
      recency_vld[i] = 1'b0;
    end

    in_valid         <= 1'b0;
    in_operation     <= OP_ACCESS;
    in_block_address <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    rst_n            <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed trace at reset configuration
    foreach (directed[r]) begin
      send_item(directed[r].op, directed[r].addr, directed[r].typed, directed[r].want);
    end

    // Random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      act = ph_act[ph];
      for (int k = 0; k < 4; k++) sz[k] = ph_size[ph][k];
      if (ph_rand[ph]) begin
        act = $urandom_range(0, 7);
        for (int k = 0; k < 4; k++) sz[k] = $urandom_range(0, 127);
      end
      // junk above the field width must be dropped
      junk = $urandom_range(0, 1) ? $urandom() : '0;
      write_reg(REG_ACTIVE, (junk & ~DATA_W'(3'h7)) | DATA_W'(act));
      for (int k = 0; k < NUM_SIZE_REGS; k++) begin
        junk = $urandom_range(0, 1) ? $urandom() : '0;
        write_reg(REG_SIZE0 + REG_W'(k), (junk & ~DATA_W'(7'h7F)) | DATA_W'(sz[k]));
      end
      // unused register slots are ignored
      if (ph == 2) begin
        for (int r = int'(REG_SIZE_LAST) + 1; r < (1 << REG_W); r++) begin
          write_reg(REG_W'(r), $urandom());
        end
      end
      settings_used++;

      gap_on = (ph % 3 != 1);
      base   = AW'($urandom());
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        if ($urandom_range(0, 49) == 0) wait_drained();
        if ($urandom_range(0, 7) == 0) begin
          send_item(OP_REPORT, AW'($urandom()), 1'b0, '0);
        end else begin
          if ($urandom_range(0, 19) == 0) addr = AW'($urandom());
          else addr = base + AW'($urandom_range(0, ph_pool[ph] - 1));
          send_item(OP_ACCESS, addr, 1'b0, '0);
        end
      end
      send_item(OP_REPORT, '0, 1'b0, '0);
    end

    wait_drained();
    $display("%0d items (%0d reports) over %0d register settings, %0d counts checked",
             items_sent, reports_sent, settings_used, counts_checked);
    $display("covered stack overflow, zero/oversized capacities, 0..7 active sizes");
    if (errors == 0) begin
      $display("tb_lru_stack_distance_miss_counter passed");
    end else begin
      $display("tb_lru_stack_distance_miss_counter failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("tb_lru_stack_distance_miss_counter failed");
    $finish;
  end

endmodule
